[hw/rtl/linear_blend_skinning_top_assert.svh]
// Assertion macros for the skinning block checker.
// Needs nothing else; included by the checker file only.
`ifndef LINEAR_BLEND_SKINNING_TOP_ASSERT_SVH
`define LINEAR_BLEND_SKINNING_TOP_ASSERT_SVH

// Check a property outside reset
`define LBS_ASSERT_RUN(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included
`define LBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/lbs_pkg.sv]
// Shared types, codes and helpers for the linear blend skinning block.
// No dependencies; used by the front, back, divider and top level.
package lbs_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD_BONE = 2'd0,
    CMD_LOAD_PATH = 2'd1,
    CMD_INFLUENCE = 2'd2,
    CMD_UNSKINNED = 2'd3
  } command_t;

  localparam logic SCALE_UNIT  = 1'b0;
  localparam logic SCALE_CENTI = 1'b1;

  typedef struct packed {
    command_t           command;
    logic [7:0]         bone_index;
    logic               bone_ok;
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [16:0]        weight;
    logic               last_influence;
  } item_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               zero_w;
  } result_t;

  typedef struct packed {
    logic               start;
    logic               scale_sel;
    logic signed [63:0] num_x;
    logic signed [63:0] num_y;
    logic signed [63:0] num_z;
    logic signed [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] q_x;
    logic signed [31:0] q_y;
    logic signed [31:0] q_z;
  } div_rsp_t;

  // Magnitude of a signed 64-bit value; the most negative value maps to 2^63
  function automatic logic [63:0] mag64(input logic [63:0] a);
    logic [63:0] r;
    r = a[63] ? (~a + 64'd1) : a;
    return r;
  endfunction

endpackage

[hw/rtl/lbs_front.sv]
// Front part: takes input transfers, classifies the bone index, queues items.
// Depends on lbs_pkg.
module lbs_front #(
  parameter int MAX_BONES = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           command,
  input  logic [7:0]           bone_index,
  input  logic [3:0]           element_index,
  input  logic signed [31:0]   element_value,
  input  logic signed [31:0]   pos_x,
  input  logic signed [31:0]   pos_y,
  input  logic signed [31:0]   pos_z,
  input  logic [16:0]          weight,
  input  logic                 last_influence,
  output logic                 q_valid,
  output lbs_pkg::item_t       q_item,
  input  logic                 q_pop
);

  lbs_pkg::item_t slot [2];
  lbs_pkg::item_t item;
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           accept;
  logic [12:0]    bone_ext;

  // Classify the item on entry
  assign bone_ext = {5'd0, bone_index};
  always_comb begin
    item.command        = lbs_pkg::command_t'(command);
    item.bone_index     = bone_index;
    item.bone_ok        = bone_ext < 13'(MAX_BONES);
    item.element_index  = element_index;
    item.element_value  = element_value;
    item.pos_x          = pos_x;
    item.pos_y          = pos_y;
    item.pos_z          = pos_z;
    item.weight         = weight;
    item.last_influence = last_influence;
  end

  assign in_stall = (count == 2'd2);
  assign accept   = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];

  // Advance the queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, accept} - {1'b0, q_pop};
    end
  end

  // Hold the queued payload
  always_ff @(posedge clk) begin
    if (accept) slot[wr_ptr] <= item;
  end

endmodule

[hw/rtl/lbs_div.sv]
// Shared restoring divider: three quotients over one scaled w, one bit a cycle.
// Depends on lbs_pkg.
module lbs_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  lbs_pkg::div_req_t req,
  output lbs_pkg::div_rsp_t rsp
);

  localparam int NW = 64 + FRAC_BITS;
  localparam int DW = 71;
  localparam int CW = $clog2(NW + 1);
  localparam logic [33:0] CAP = 34'h200000000;

  typedef enum logic [3:0] {
    DV_IDLE = 4'b0001,
    DV_PREP = 4'b0010,
    DV_RUN  = 4'b0100,
    DV_DONE = 4'b1000
  } dstate_t;

  dstate_t         state;
  logic [CW-1:0]   cnt;
  logic [63:0]     md;
  logic            scale;
  logic [DW-1:0]   dd;
  logic [DW-1:0]   md_ext;
  logic [2:0]      neg;
  logic [NW-1:0]   n   [3];
  logic [DW-1:0]   rem [3];
  logic [33:0]     q   [3];
  logic [63:0]     num [3];

  assign num[0] = req.num_x;
  assign num[1] = req.num_y;
  assign num[2] = req.num_z;
  assign md_ext = DW'(md);

  // Saturate a quotient to signed 32 bits
  function automatic logic [31:0] sat_q(input logic [33:0] qv, input logic ng);
    logic [33:0] r;
    if (ng) begin
      r = (qv > 34'h080000000) ? 34'h080000000 : qv;
      r = 34'd0 - r;
    end else begin
      r = (qv > 34'h07FFFFFFF) ? 34'h07FFFFFFF : qv;
    end
    return r[31:0];
  endfunction

  // Sequence: latch, scale the divisor, iterate, report
  always_ff @(posedge clk) begin
    logic [DW:0] rem2;
    logic        ge;
    logic [34:0] qn;
    if (rst) begin
      state <= DV_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        DV_IDLE: begin
          if (req.start) begin
            md    <= lbs_pkg::mag64(req.den);
            scale <= req.scale_sel;
            for (int i = 0; i < 3; i++) begin
              neg[i] <= num[i][63] ^ req.den[63];
              n[i]   <= {lbs_pkg::mag64(num[i]), {FRAC_BITS{1'b0}}};
              rem[i] <= '0;
              q[i]   <= '0;
            end
            state <= DV_PREP;
          end
        end
        DV_PREP: begin
          dd    <= (scale == lbs_pkg::SCALE_CENTI)
                   ? (md_ext << 6) + (md_ext << 5) + (md_ext << 2) : md_ext;
          cnt   <= '0;
          state <= DV_RUN;
        end
        DV_RUN: begin
          for (int i = 0; i < 3; i++) begin
            rem2 = {rem[i], n[i][NW-1]};
            ge   = rem2 >= {1'b0, dd};
            rem[i] <= ge ? DW'(rem2 - {1'b0, dd}) : rem2[DW-1:0];
            n[i]   <= n[i] << 1;
            qn     = {q[i], ge};
            q[i]   <= (qn > 35'(CAP)) ? CAP : qn[33:0];
          end
          cnt <= cnt + 1'b1;
          if (cnt == CW'(NW - 1)) state <= DV_DONE;
        end
        DV_DONE: state <= DV_IDLE;
        default: state <= DV_IDLE;
      endcase
    end
  end

  assign rsp.done = (state == DV_DONE);
  assign rsp.q_x  = sat_q(q[0], neg[0]);
  assign rsp.q_y  = sat_q(q[1], neg[1]);
  assign rsp.q_z  = sat_q(q[2], neg[2]);

endmodule

[hw/rtl/lbs_back.sv]
// Back part: matrix stores, transform sequencer, weighting, accumulators and
// the output register. Depends on lbs_pkg; drives the lbs_div unit.
module lbs_back #(
  parameter int MAX_BONES = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  lbs_pkg::item_t    q_item,
  output logic              q_pop,
  input  logic              scale_sel,
  output lbs_pkg::div_req_t div_req,
  input  lbs_pkg::div_rsp_t div_rsp,
  output logic              res_valid,
  output lbs_pkg::result_t  res,
  input  logic              res_take
);

  localparam int BIW   = $clog2(MAX_BONES);
  localparam int AW    = BIW + 4;
  localparam int DEPTH = MAX_BONES * 16;
  localparam logic signed [63:0] S64_MAX = 64'sh7FFFFFFFFFFFFFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000000000000000;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_XFORM  = 6'b000010,
    ST_WEIGHT = 6'b000100,
    ST_FINISH = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_PUSH   = 6'b100000
  } state_t;

  state_t             state;
  state_t             state_next;
  lbs_pkg::item_t     cur;
  logic signed [31:0] palette [DEPTH];
  logic signed [31:0] path    [16];
  logic [12:0]        wr_bone_ext;
  logic [12:0]        rd_bone_ext;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic [4:0]         iss_cnt;
  logic               rd_v;
  logic [3:0]         rd_idx;
  logic signed [31:0] mem_q;
  logic signed [31:0] path_q;
  logic               t_v;
  logic [3:0]         t_idx;
  logic signed [63:0] term;
  logic signed [63:0] term_c;
  logic signed [63:0] row_sum;
  logic signed [63:0] v   [4];
  logic signed [63:0] acc [4];
  logic [2:0]         wcnt;
  logic               wp_v;
  logic [1:0]         wp_row;
  logic signed [63:0] wp;
  logic signed [63:0] wp_c;
  lbs_pkg::result_t   pend;
  logic               unsk;
  logic               emit;
  logic               xform_end;
  logic signed [63:0] den_sel;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  assign wr_bone_ext = {5'd0, q_item.bone_index};
  assign rd_bone_ext = {5'd0, cur.bone_index};
  assign wr_addr     = {wr_bone_ext[BIW-1:0], q_item.element_index};
  assign rd_addr     = {rd_bone_ext[BIW-1:0], iss_cnt[3:0]};
  assign unsk        = (cur.command == lbs_pkg::CMD_UNSKINNED);
  assign emit        = unsk || cur.last_influence;
  assign xform_end   = t_v && (t_idx == 4'd15);
  assign den_sel     = unsk ? v[3] : acc[3];

  // One matrix element times its coordinate, truncated toward zero; column 3 is the element alone
  always_comb begin
    logic signed [31:0] el;
    logic signed [31:0] co;
    logic [31:0]        ma;
    logic [31:0]        mb;
    logic [63:0]        prod;
    logic [63:0]        sh;
    el = unsk ? path_q : mem_q;
    case (rd_idx[1:0])
      2'd0:    co = cur.pos_x;
      2'd1:    co = cur.pos_y;
      default: co = cur.pos_z;
    endcase
    ma   = el[31] ? (~el + 32'd1) : el;
    mb   = co[31] ? (~co + 32'd1) : co;
    prod = 64'(ma) * 64'(mb);
    sh   = prod >> FRAC_BITS;
    if (rd_idx[1:0] == 2'd3) term_c = {{32{el[31]}}, el};
    else term_c = (el[31] != co[31]) ? (64'd0 - sh) : sh;
  end

  // Weight one transformed component, truncated toward zero
  always_comb begin
    logic signed [63:0] wv;
    logic [63:0]        mw;
    logic [80:0]        wprod;
    logic [63:0]        wsh;
    wv    = v[wcnt[1:0]];
    mw    = lbs_pkg::mag64(wv);
    wprod = 81'(mw) * 81'(cur.weight);
    wsh   = wprod[79:16];
    wp_c  = wv[63] ? (64'd0 - wsh) : wsh;
  end

  // Sequence the item through the back part
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_item.command)
            lbs_pkg::CMD_INFLUENCE: state_next = q_item.bone_ok ? ST_XFORM : ST_FINISH;
            lbs_pkg::CMD_UNSKINNED: state_next = ST_XFORM;
            default:                state_next = ST_IDLE;
          endcase
        end
      end
      ST_XFORM:  if (xform_end) state_next = unsk ? ST_FINISH : ST_WEIGHT;
      ST_WEIGHT: if (wcnt == 3'd4) state_next = ST_FINISH;
      ST_FINISH: begin
        if (!emit) state_next = ST_IDLE;
        else if (den_sel == 64'sd0) state_next = ST_PUSH;
        else state_next = ST_DIV;
      end
      ST_DIV:    if (div_rsp.done) state_next = ST_PUSH;
      ST_PUSH:   if (!res_valid || res_take) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Request a division for a non-zero w
  always_comb begin
    div_req.start     = (state == ST_FINISH) && emit && (den_sel != 64'sd0);
    div_req.scale_sel = scale_sel;
    div_req.num_x     = unsk ? v[0] : acc[0];
    div_req.num_y     = unsk ? v[1] : acc[1];
    div_req.num_z     = unsk ? v[2] : acc[2];
    div_req.den       = den_sel;
  end

  // Palette writes and registered reads
  always_ff @(posedge clk) begin
    if (q_pop && q_item.command == lbs_pkg::CMD_LOAD_BONE && q_item.bone_ok)
      palette[wr_addr] <= q_item.element_value;
    mem_q <= palette[rd_addr];
  end

  // Control, path matrix and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_v      <= 1'b0;
      t_v       <= 1'b0;
      wp_v      <= 1'b0;
      iss_cnt   <= '0;
      wcnt      <= '0;
      row_sum   <= '0;
      res_valid <= 1'b0;
      for (int i = 0; i < 16; i++)
        path[i] <= (i % 5 == 0) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
      for (int i = 0; i < 4; i++) acc[i] <= '0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        cur     <= q_item;
        iss_cnt <= '0;
        if (q_item.command == lbs_pkg::CMD_LOAD_PATH)
          path[q_item.element_index] <= q_item.element_value;
      end
      path_q <= path[iss_cnt[3:0]];

      // Issue element reads
      if (state == ST_XFORM && iss_cnt < 5'd16) begin
        rd_v    <= 1'b1;
        rd_idx  <= iss_cnt[3:0];
        iss_cnt <= iss_cnt + 5'd1;
      end else begin
        rd_v <= 1'b0;
      end

      // Register the product term
      t_v   <= rd_v;
      t_idx <= rd_idx;
      term  <= term_c;

      // Sum each row
      if (t_v) begin
        if (t_idx[1:0] == 2'd3) begin
          v[t_idx[3:2]] <= row_sum + term;
          row_sum       <= '0;
        end else begin
          row_sum <= row_sum + term;
        end
      end
      if (xform_end) wcnt <= '0;

      // Weight the rows and accumulate
      if (state == ST_WEIGHT && wcnt < 3'd4) begin
        wp_v   <= 1'b1;
        wp_row <= wcnt[1:0];
        wp     <= wp_c;
        wcnt   <= wcnt + 3'd1;
      end else begin
        wp_v <= 1'b0;
      end
      if (wp_v) acc[wp_row] <= sat_add(acc[wp_row], wp);

      // Close the vertex
      if (state == ST_FINISH && emit) begin
        if (!unsk) for (int i = 0; i < 4; i++) acc[i] <= '0;
        if (den_sel == 64'sd0) pend <= '{x: '0, y: '0, z: '0, zero_w: 1'b1};
      end
      if (state == ST_DIV && div_rsp.done)
        pend <= '{x: div_rsp.q_x, y: div_rsp.q_y, z: div_rsp.q_z, zero_w: 1'b0};

      // Output register
      if (state == ST_PUSH && (!res_valid || res_take)) begin
        res       <= pend;
        res_valid <= 1'b1;
      end else if (res_take) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/linear_blend_skinning_top.sv]
// Top level of the linear blend skinning block.
// Depends on lbs_pkg, lbs_front, lbs_back and lbs_div.
//
//   channel   handshake              payload
//   input     in_valid / in_stall    command .. last_influence
//   output    out_valid / out_stall  out_x, out_y, out_z, zero_w_error
//   config    cfg_wr_en              cfg_wr_data (scale_select)
//
// A transfer is registered in the queue before the back part takes it. A load
// leaves the back part idle, so loads can follow back to back. A transform reads
// 16 elements one a cycle from the one palette read port or, for an unskinned
// vertex, the path matrix. An influence is taken, transformed, weighted and
// closed; an unskinned vertex is not weighted. A result then takes the bit-serial
// divider and output register, or the output register alone when w is zero.
// Reset is synchronous; path matrix returns to identity, accumulators to zero,
// scale_select to 1. A result held at the output keeps the back part waiting;
// the two-entry queue then fills and raises in_stall.
module linear_blend_skinning_top #(
  parameter int MAX_BONES = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          command,
  input  logic [7:0]          bone_index,
  input  logic [3:0]          element_index,
  input  logic signed [31:0]  element_value,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  pos_z,
  input  logic [16:0]         weight,
  input  logic                last_influence,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_z,
  output logic                zero_w_error
);

  logic              scale_sel;
  logic              q_valid;
  logic              q_pop;
  lbs_pkg::item_t    q_item;
  lbs_pkg::div_req_t div_req;
  lbs_pkg::div_rsp_t div_rsp;
  lbs_pkg::result_t  res;

  // Hold the scale register
  always_ff @(posedge clk) begin
    if (rst) scale_sel <= lbs_pkg::SCALE_CENTI;
    else if (cfg_wr_en) scale_sel <= cfg_wr_data;
  end

  lbs_front #(.MAX_BONES(MAX_BONES)) u_front (
    .clk, .rst, .in_valid, .in_stall, .command, .bone_index, .element_index,
    .element_value, .pos_x, .pos_y, .pos_z, .weight, .last_influence,
    .q_valid, .q_item, .q_pop
  );

  lbs_back #(.MAX_BONES(MAX_BONES), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst, .q_valid, .q_item, .q_pop, .scale_sel, .div_req, .div_rsp,
    .res_valid(out_valid), .res, .res_take(out_valid && !out_stall)
  );

  lbs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk, .rst, .req(div_req), .rsp(div_rsp)
  );

  assign out_x        = res.x;
  assign out_y        = res.y;
  assign out_z        = res.z;
  assign zero_w_error = res.zero_w;

endmodule

[hw/rtl/lbs_checker.sv]
// Port-level checker for the skinning block, bound to the top level.
// Depends on linear_blend_skinning_top_assert.svh.
`include "linear_blend_skinning_top_assert.svh"

module lbs_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_x,
  input logic signed [31:0] out_y,
  input logic signed [31:0] out_z,
  input logic               zero_w_error
);

  `LBS_ASSERT_RUN(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `LBS_ASSERT_RUN(a_out_stable, clk, rst, out_valid && out_stall |=> $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(zero_w_error), "stalled result changed")
  `LBS_ASSERT_RUN(a_zero_w, clk, rst, out_valid && zero_w_error |-> out_x == 32'sd0 && out_y == 32'sd0 && out_z == 32'sd0, "zero w result not cleared")
  `LBS_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid && !in_stall, "block not empty after reset")

endmodule

bind linear_blend_skinning_top lbs_checker u_lbs_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_x(out_x), .out_y(out_y), .out_z(out_z),
  .zero_w_error(zero_w_error)
);

[bench/linear_blend_skinning_top_tb.sv]
// Self-checking bench for the linear blend skinning top level: random and directed
// transfers, an in-bench fixed-point predictor and a result scoreboard.
// Depends on lbs_pkg and linear_blend_skinning_top.
`timescale 1ns / 100ps

module linear_blend_skinning_top_tb;

  localparam int ONE_Q16 = 65536;
  localparam int DRAIN_CYCLES = 250;
  localparam int LONG_HOLD = 400;

  typedef struct {
    lbs_pkg::command_t  cmd;
    logic [7:0]         bone;
    logic [3:0]         elem;
    logic signed [31:0] val;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [16:0]        wt;
    logic               last;
  } skin_req_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               zw;
  } vertex_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] command = '0;
  logic [7:0] bone_index = '0;
  logic [3:0] element_index = '0;
  logic signed [31:0] element_value = '0;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_y = '0;
  logic signed [31:0] pos_z = '0;
  logic [16:0] weight = '0;
  logic last_influence = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_x, out_y, out_z;
  logic zero_w_error;

  linear_blend_skinning_top u_dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .bone_index(bone_index), .element_index(element_index),
    .element_value(element_value), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .weight(weight), .last_influence(last_influence),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .zero_w_error(zero_w_error)
  );

  // Queues between stimulus, driver and scoreboard
  skin_req_t   pending_reqs[$];
  skin_req_t   cur_req;
  vertex_out_t expected_verts[$];

  // Predictor state
  logic signed [31:0] pal_q[256][16];
  logic signed [31:0] path_q[16];
  logic signed [63:0] sum_x, sum_y, sum_z, sum_w;
  logic               centi_scale;

  // Generator bookkeeping
  logic gen_set[256][16];
  int   ready_bones[$];
  int   items_pushed = 0;

  int   fail_count = 0;
  logic in_took = 1'b0;
  int   in_gap = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  int   hold_requests = 0;
  int   holds_done = 0;
  logic quiet = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #30ms;
    $display("Some tests failed");
    $finish;
  end

  // ---------------- predictor ----------------
  function automatic logic [63:0] abs64(logic signed [63:0] a);
    return a[63] ? (~a + 64'd1) : a;
  endfunction

  // Q16 element times coordinate, truncated toward zero
  function automatic logic signed [63:0] elem_mul(logic signed [31:0] e,
                                                  logic signed [63:0] p);
    logic [127:0] m;
    logic signed [63:0] r;
    m = ({64'd0, abs64(64'(e))} * {64'd0, abs64(p)}) >> 16;
    r = m[63:0];
    return (e[31] != p[63]) ? -r : r;
  endfunction

  function automatic logic signed [63:0] weigh(logic signed [63:0] v, logic [16:0] w);
    logic [127:0] m;
    logic signed [63:0] r;
    m = ({64'd0, abs64(v)} * 128'(w)) >> 16;
    r = m[63:0];
    return v[63] ? -r : r;
  endfunction

  function automatic logic signed [63:0] clamp_add(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return s[63:0];
  endfunction

  // trunc(num * 2^16 / (den * scale)), saturated to 32 bits
  function automatic logic signed [31:0] divide_q(logic signed [63:0] num,
                                                  logic signed [63:0] den);
    logic [127:0] n, d, q;
    n = {64'd0, abs64(num)} << 16;
    d = {64'd0, abs64(den)} * (centi_scale ? 128'd100 : 128'd1);
    q = n / d;
    if (num[63] != den[63]) begin
      if (q > 128'h8000_0000) q = 128'h8000_0000;
      return -q[31:0];
    end
    if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
    return q[31:0];
  endfunction

  function automatic vertex_out_t finish_vertex(logic signed [63:0] x, logic signed [63:0] y,
                                                logic signed [63:0] z, logic signed [63:0] w);
    vertex_out_t o;
    if (w == 0) begin
      o = '{0, 0, 0, 1'b1};
    end else begin
      o = '{divide_q(x, w), divide_q(y, w), divide_q(z, w), 1'b0};
    end
    return o;
  endfunction

  task automatic predict_transfer(skin_req_t r);
    logic signed [63:0] v[4];
    logic signed [31:0] m[16];
    for (int i = 0; i < 16; i++)
      m[i] = (r.cmd == lbs_pkg::CMD_UNSKINNED) ? path_q[i] : pal_q[r.bone][i];
    for (int k = 0; k < 4; k++) begin
      v[k] = elem_mul(m[k*4], 64'(r.px)) + elem_mul(m[k*4+1], 64'(r.py))
           + elem_mul(m[k*4+2], 64'(r.pz)) + 64'(m[k*4+3]);
    end
    case (r.cmd)
      lbs_pkg::CMD_LOAD_BONE: pal_q[r.bone][r.elem] = r.val;
      lbs_pkg::CMD_LOAD_PATH: path_q[r.elem] = r.val;
      lbs_pkg::CMD_UNSKINNED:
        expected_verts = {expected_verts, finish_vertex(v[0], v[1], v[2], v[3])};
      default: begin
        sum_x = clamp_add(sum_x, weigh(v[0], r.wt));
        sum_y = clamp_add(sum_y, weigh(v[1], r.wt));
        sum_z = clamp_add(sum_z, weigh(v[2], r.wt));
        sum_w = clamp_add(sum_w, weigh(v[3], r.wt));
        if (r.last) begin
          expected_verts = {expected_verts, finish_vertex(sum_x, sum_y, sum_z, sum_w)};
          sum_x = 0; sum_y = 0; sum_z = 0; sum_w = 0;
        end
      end
    endcase
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // ---------------- driver and receiver ----------------
  // Present the next transfer once the previous one has gone
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_took)) begin
      if (!quiet && in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        cur_req = pending_reqs.pop_front();
        command <= cur_req.cmd;
        bone_index <= cur_req.bone;
        element_index <= cur_req.elem;
        element_value <= cur_req.val;
        pos_x <= cur_req.px;
        pos_y <= cur_req.py;
        pos_z <= cur_req.pz;
        weight <= cur_req.wt;
        last_influence <= cur_req.last;
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) in_gap <= $urandom_range(1, 5);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the output in short bursts, and once in a long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (holds_done != hold_requests) begin
      holds_done <= holds_done + 1;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (!quiet && stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Predict on input transfers, check on output transfers
  always @(posedge clk) begin
    in_took <= in_valid && !in_stall && !rst;
    if (!rst) begin
      if (in_valid && !in_stall) predict_transfer(cur_req);
      if (out_valid && !out_stall) begin
        if (expected_verts.size() == 0) begin
          report_mismatch("unexpected result", out_x, 0);
        end else begin
          vertex_out_t e;
          e = expected_verts.pop_front();
          if (out_x !== e.x) report_mismatch("out_x", out_x, e.x);
          if (out_y !== e.y) report_mismatch("out_y", out_y, e.y);
          if (out_z !== e.z) report_mismatch("out_z", out_z, e.z);
          if (zero_w_error !== e.zw) report_mismatch("zero_w_error", zero_w_error, e.zw);
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      2: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
      default: return $signed($urandom_range(0, 200 * ONE_Q16)) - 100 * ONE_Q16;
    endcase
  endfunction

  function automatic skin_req_t noise_req(lbs_pkg::command_t c);
    skin_req_t r;
    r.cmd = c;
    r.bone = 8'($urandom());
    r.elem = 4'($urandom());
    r.val = $urandom();
    r.px = pick_value();
    r.py = pick_value();
    r.pz = pick_value();
    r.wt = 17'($urandom());
    r.last = 1'($urandom());
    return r;
  endfunction

  task automatic push_req(skin_req_t r);
    pending_reqs = {pending_reqs, r};
    items_pushed++;
  endtask

  task automatic load_element(lbs_pkg::command_t c, int b, int e, logic signed [31:0] v);
    skin_req_t r;
    r = noise_req(c);
    r.bone = 8'(b);
    r.elem = 4'(e);
    r.val = v;
    push_req(r);
    if (c == lbs_pkg::CMD_LOAD_BONE) begin
      bit full;
      gen_set[b][e] = 1'b1;
      full = 1'b1;
      for (int i = 0; i < 16; i++) full &= gen_set[b][i];
      if (full && !(b inside {ready_bones})) ready_bones = {ready_bones, b};
    end
  endtask

  // Random affine-ish matrix; the bottom row is mostly near (0, 0, 0, 1)
  task automatic load_bone(int b, bit unit);
    logic signed [31:0] v;
    for (int e = 0; e < 16; e++) begin
      if (unit)
        v = (e % 5 == 0) ? ONE_Q16
          : ((e % 4 == 3) ? $signed($urandom_range(0, 1 << 20)) : 0);
      else if (e >= 12 && $urandom_range(0, 5) != 0)
        v = (e == 15) ? ONE_Q16 + $signed($urandom_range(0, 8192)) - 4096
                      : $signed($urandom_range(0, 64)) - 32;
      else v = pick_value();
      load_element(lbs_pkg::CMD_LOAD_BONE, b, e, v);
    end
  endtask

  task automatic push_vertex_op(lbs_pkg::command_t c, int b, int w, bit last);
    skin_req_t r;
    r = noise_req(c);
    r.bone = 8'(b);
    r.wt = 17'(w);
    r.last = last;
    push_req(r);
  endtask

  function automatic int random_weight();
    case ($urandom_range(0, 7))
      0: return $urandom_range(65536, 131071);
      1: return $urandom_range(0, 1) ? 0 : 65536;
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  task automatic random_stretch(int target);
    int goal, n;
    goal = items_pushed + target;
    while (items_pushed < goal) begin
      case ($urandom_range(0, 11))
        0: load_bone($urandom_range(0, 255), 1'b0);
        1: load_element(lbs_pkg::CMD_LOAD_BONE, $urandom_range(0, 255),
                        $urandom_range(0, 15), pick_value());
        2: load_element(lbs_pkg::CMD_LOAD_PATH, $urandom_range(0, 255), $urandom_range(0, 15),
                        $urandom_range(0, 3) == 0 ? ONE_Q16 : pick_value());
        3: push_vertex_op(lbs_pkg::CMD_UNSKINNED, $urandom(), $urandom(), 1'($urandom()));
        default: begin
          // Well-formed vertex; now and then an unskinned vertex inside, or no last flag
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
              push_vertex_op(lbs_pkg::CMD_UNSKINNED, $urandom(), $urandom(), 1'b1);
            push_vertex_op(lbs_pkg::CMD_INFLUENCE,
                           ready_bones[$urandom_range(0, ready_bones.size() - 1)],
                           random_weight(), (i == n - 1) && ($urandom_range(0, 11) != 0));
          end
        end
      endcase
    end
  endtask

  // Hold until every transfer is taken and every result checked, then settle
  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (expected_verts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_scale(logic s);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= s;
    centi_scale = s;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    for (int b = 0; b < 256; b++) begin
      for (int e = 0; e < 16; e++) begin
        pal_q[b][e] = 0;
        gen_set[b][e] = 1'b0;
      end
    end
    for (int e = 0; e < 16; e++) path_q[e] = (e % 5 == 0) ? ONE_Q16 : 0;
    sum_x = 0; sum_y = 0; sum_z = 0; sum_w = 0;
    centi_scale = lbs_pkg::SCALE_CENTI;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: identity path, extremes, zero w, weight corners, unskinned amid influences
    load_bone(0, 1'b1);
    load_bone(255, 1'b0);
    begin
      skin_req_t r;
      r = noise_req(lbs_pkg::CMD_UNSKINNED);
      r.px = 32'sh7FFF_FFFF; r.py = 32'sh8000_0000; r.pz = 0;
      push_req(r);
      r.px = 32'sh8000_0000; r.py = 32'sh7FFF_FFFF; r.pz = ONE_Q16;
      push_req(r);
    end
    load_element(lbs_pkg::CMD_LOAD_PATH, 0, 15, 0);
    push_vertex_op(lbs_pkg::CMD_UNSKINNED, 0, 0, 1'b0);
    load_element(lbs_pkg::CMD_LOAD_PATH, 0, 0, 32'sh7FFF_FFFF);
    load_element(lbs_pkg::CMD_LOAD_PATH, 0, 15, 1);
    push_vertex_op(lbs_pkg::CMD_UNSKINNED, 0, 0, 1'b1);
    load_element(lbs_pkg::CMD_LOAD_PATH, 0, 0, 32'sh8000_0000);
    push_vertex_op(lbs_pkg::CMD_UNSKINNED, 0, 0, 1'b1);
    load_element(lbs_pkg::CMD_LOAD_PATH, 0, 0, ONE_Q16);
    load_element(lbs_pkg::CMD_LOAD_PATH, 0, 15, ONE_Q16);
    push_vertex_op(lbs_pkg::CMD_INFLUENCE, 0, 0, 1'b1);
    push_vertex_op(lbs_pkg::CMD_INFLUENCE, 0, 65536, 1'b1);
    push_vertex_op(lbs_pkg::CMD_INFLUENCE, 255, 131071, 1'b0);
    push_vertex_op(lbs_pkg::CMD_UNSKINNED, 0, 0, 1'b0);
    push_vertex_op(lbs_pkg::CMD_INFLUENCE, 0, 1, 1'b1);
    random_stretch(120);
    drain();

    set_scale(lbs_pkg::SCALE_UNIT);
    hold_requests++;
    random_stretch(140);
    drain();

    set_scale(lbs_pkg::SCALE_CENTI);
    random_stretch(130);
    drain();

    set_scale(lbs_pkg::SCALE_UNIT);
    quiet = 1'b1;
    random_stretch(100);
    drain();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
